/* rtl/wmads_pkg.sv */
// Shared types and constants for the sliding-window median deviation block.
package wmads_pkg;

  // Default sizing of the storage.
  localparam int WINDOW_MAX_DEF   = 1024;
  localparam int VALUE_LEVELS_DEF = 256;

  // Fixed field widths.
  localparam int SAMPLE_W = 8;
  localparam int DEV_W    = 18;
  localparam int MED_W    = 8;
  localparam int WSIZE_W  = 11;

  // Register file of the configuration port.
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [WSIZE_W-1:0]   WSIZE_RESET     = 11'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OLD,
    ST_DEC,
    ST_INC_RD,
    ST_INC_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control handed from the sequencer to the histogram scan pipeline.
  typedef struct packed {
    logic start;
    logic vld;
    logic last;
  } scan_ctl_t;

endpackage

/* rtl/wmads_scan.sv */
// Histogram scan pipeline: locates the lower median and accumulates the deviation sum.
module wmads_scan #(
  parameter int WINDOW_MAX   = wmads_pkg::WINDOW_MAX_DEF,
  parameter int VALUE_LEVELS = wmads_pkg::VALUE_LEVELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wmads_pkg::scan_ctl_t            ctl,
  input  logic [$clog2(VALUE_LEVELS)-1:0] bin,
  input  logic [$clog2(WINDOW_MAX+1)-1:0] count,
  input  logic [$clog2(WINDOW_MAX+1)-1:0] k,
  input  logic [$clog2(WINDOW_MAX+1)-1:0] rem,
  output logic                            done,
  output logic [wmads_pkg::DEV_W-1:0]     dev_sum,
  output logic [wmads_pkg::MED_W-1:0]     median
);

  localparam int BW = $clog2(VALUE_LEVELS);
  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic [CW-1:0] cum_r, cum_nxt;
  logic [CW-1:0] cum_p_r;
  logic [BW-1:0] bin_b_r;
  logic          b_vld_r, b_last_r;
  logic          found_r;
  logic [BW-1:0] median_r;
  logic [CW-1:0] term_r;
  logic          c_vld_r, c_last_r;
  logic [wmads_pkg::DEV_W-1:0] acc_r;
  logic          done_r;
  logic          hit;

  assign cum_nxt = cum_r + count;
  assign hit     = (cum_p_r >= rem);

  // Control flags of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r  <= 1'b0;
      b_last_r <= 1'b0;
      c_vld_r  <= 1'b0;
      c_last_r <= 1'b0;
      done_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      b_vld_r  <= ctl.vld;
      b_last_r <= ctl.vld & ctl.last;
      c_vld_r  <= b_vld_r;
      c_last_r <= b_vld_r & b_last_r;
      done_r   <= c_vld_r & c_last_r;
      if (ctl.start) begin
        found_r <= 1'b0;
      end else if (b_vld_r) begin
        found_r <= found_r | hit;
      end
    end
  end

  // Below the median a bin adds the count at or under it, from the median up
  // it adds the count above it; together they give the absolute deviation sum.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cum_r <= '0;
    end else if (ctl.vld) begin
      cum_r <= cum_nxt;
    end
    cum_p_r <= cum_nxt;
    bin_b_r <= bin;
    if (b_vld_r) begin
      if (hit && !found_r) begin
        median_r <= bin_b_r;
      end
      term_r <= (found_r || hit) ? k - cum_p_r : cum_p_r;
    end
    if (ctl.start) begin
      acc_r <= '0;
    end else if (c_vld_r) begin
      acc_r <= acc_r + wmads_pkg::DEV_W'(term_r);
    end
  end

  assign done    = done_r;
  assign dev_sum = acc_r;
  assign median  = wmads_pkg::MED_W'(median_r);

endmodule

/* rtl/window_median_abs_deviation_sum_top.sv */
// Top level of the sliding-window median absolute deviation sum block.
//
//   Channel  Direction  Handshake        Payload
//   in_      input      valid / ready    sample (8 bits)
//   out_     output     valid / ready    deviation_sum (18 bits), window_median (8 bits)
//   cfg_     input      APB-style write  window_size at byte address 0
//
// A sample that leaves the window not yet full passes through ST_INC_RD and
// ST_INC_WR only. A sample that completes or extends a full window also goes
// through ST_SCAN, ST_DRAIN and ST_DONE: the histogram memory's single read port
// is swept once over every bin. After reset, and after every write of
// window_size, a clearing pass over every bin zeroes the histogram while in_ready
// stays low. A stalled result waits in the output register;
// a following result is only loaded once that one has been taken.
module window_median_abs_deviation_sum_top #(
  parameter int WINDOW_MAX   = wmads_pkg::WINDOW_MAX_DEF,
  parameter int VALUE_LEVELS = wmads_pkg::VALUE_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Sample input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wmads_pkg::SAMPLE_W-1:0]    in_sample,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wmads_pkg::DEV_W-1:0]       out_deviation_sum,
  output logic [wmads_pkg::MED_W-1:0]       out_window_median,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wmads_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [wmads_pkg::PDATA_W-1:0]     cfg_pwdata,
  output logic [wmads_pkg::PDATA_W-1:0]     cfg_prdata,
  output logic                              cfg_pready
);

  // Bin index, window count and ring address widths.
  localparam int BW = $clog2(VALUE_LEVELS);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int RW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [BW-1:0] LAST_BIN = BW'(VALUE_LEVELS - 1);

  // The sample ring holds the window in arrival order; the histogram holds
  // one count per value. Both memories have a registered read port.
  logic [wmads_pkg::SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
  logic [CW-1:0]                  hist_mem [VALUE_LEVELS];

  logic [wmads_pkg::SAMPLE_W-1:0] ring_q;
  logic                           ring_we;
  logic [CW-1:0]                  hist_q;
  logic [BW-1:0]                  hist_ra;
  logic                           hist_we;
  logic [BW-1:0]                  hist_wa;
  logic [CW-1:0]                  hist_wd;

  wmads_pkg::state_t state_r, state_nxt;
  logic [BW-1:0]     bin_r, bin_nxt;
  logic [RW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [wmads_pkg::WSIZE_W-1:0] wsize_r, wsize_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [BW-1:0]     s_r, s_nxt;
  logic [BW-1:0]     old_r, old_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic [BW-1:0]     rd_bin_r, rd_bin_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [wmads_pkg::DEV_W-1:0] out_sum_r, out_sum_nxt;
  logic [wmads_pkg::MED_W-1:0] out_med_r, out_med_nxt;

  logic                        cfg_wr;
  logic                        scan_start;
  logic                        scan_done;
  logic [wmads_pkg::DEV_W-1:0] scan_sum;
  logic [wmads_pkg::MED_W-1:0] scan_med;
  wmads_pkg::scan_ctl_t        scan_ctl;
  logic [CW:0]                 k_plus1;

  // Effective window: zero means one, anything above the ring depth saturates.
  always_comb begin
    if (wsize_r == '0) begin
      k_nxt = CW'(1);
    end else if (32'(wsize_r) > WINDOW_MAX) begin
      k_nxt = CW'(WINDOW_MAX);
    end else begin
      k_nxt = CW'(wsize_r);
    end
    k_plus1 = {1'b0, k_nxt} + 1'b1;
    rem_nxt = CW'(k_plus1 >> 1);
  end

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == wmads_pkg::REG_WINDOW_SIZE) ?
                      wmads_pkg::PDATA_W'(wsize_r) : '0;

  // Sequencer: next state, memory controls and register updates.
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    wsize_nxt     = wsize_r;
    s_nxt         = s_r;
    old_nxt       = old_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = 1'b0;
    rd_bin_nxt    = bin_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_sum_nxt   = out_sum_r;
    out_med_nxt   = out_med_r;
    in_ready      = 1'b0;
    ring_we       = 1'b0;
    hist_ra       = bin_r;
    hist_we       = 1'b0;
    hist_wa       = bin_r;
    hist_wd       = '0;
    scan_start    = 1'b0;

    unique case (state_r)
      wmads_pkg::ST_CLEAR: begin
        hist_we = 1'b1;
        hist_wa = bin_r;
        hist_wd = '0;
        bin_nxt = bin_r + 1'b1;
        if (bin_r == LAST_BIN) begin
          bin_nxt   = '0;
          state_nxt = wmads_pkg::ST_IDLE;
        end
      end
      wmads_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (32'(in_sample) >= VALUE_LEVELS) begin
            s_nxt = LAST_BIN;
          end else begin
            s_nxt = BW'(in_sample);
          end
          // With a full window the oldest sample leaves first; the ring
          // read at the current slot is already under way.
          if (fill_r >= k_r) begin
            state_nxt = wmads_pkg::ST_OLD;
          end else begin
            state_nxt = wmads_pkg::ST_INC_RD;
          end
        end
      end
      wmads_pkg::ST_OLD: begin
        old_nxt   = BW'(ring_q);
        hist_ra   = BW'(ring_q);
        state_nxt = wmads_pkg::ST_DEC;
      end
      wmads_pkg::ST_DEC: begin
        hist_we   = (hist_q != '0);
        hist_wa   = old_r;
        hist_wd   = hist_q - 1'b1;
        state_nxt = wmads_pkg::ST_INC_RD;
      end
      wmads_pkg::ST_INC_RD: begin
        hist_ra   = s_r;
        ring_we   = 1'b1;
        state_nxt = wmads_pkg::ST_INC_WR;
      end
      wmads_pkg::ST_INC_WR: begin
        hist_we = 1'b1;
        hist_wa = s_r;
        hist_wd = hist_q + 1'b1;
        if (32'(ptr_r) + 32'd1 >= 32'(k_r)) begin
          ptr_nxt = '0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
        if (fill_r < k_r) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (fill_nxt >= k_r) begin
          scan_start = 1'b1;
          bin_nxt    = '0;
          state_nxt  = wmads_pkg::ST_SCAN;
        end else begin
          state_nxt = wmads_pkg::ST_IDLE;
        end
      end
      wmads_pkg::ST_SCAN: begin
        hist_ra     = bin_r;
        rd_vld_nxt  = 1'b1;
        rd_bin_nxt  = bin_r;
        rd_last_nxt = (bin_r == LAST_BIN);
        bin_nxt     = bin_r + 1'b1;
        if (bin_r == LAST_BIN) begin
          bin_nxt   = '0;
          state_nxt = wmads_pkg::ST_DRAIN;
        end
      end
      wmads_pkg::ST_DRAIN: begin
        if (scan_done) begin
          state_nxt = wmads_pkg::ST_DONE;
        end
      end
      wmads_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = scan_sum;
          out_med_nxt   = scan_med;
          state_nxt     = wmads_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wmads_pkg::ST_CLEAR;
        bin_nxt   = '0;
      end
    endcase

    // A window_size write empties the window and restarts the clearing pass.
    if (cfg_wr && cfg_paddr[2] == wmads_pkg::REG_WINDOW_SIZE) begin
      wsize_nxt = cfg_pwdata[wmads_pkg::WSIZE_W-1:0];
      state_nxt = wmads_pkg::ST_CLEAR;
      bin_nxt   = '0;
      ptr_nxt   = '0;
      fill_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wmads_pkg::ST_CLEAR;
      bin_r       <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      wsize_r     <= wmads_pkg::WSIZE_RESET;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_r       <= bin_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      wsize_r     <= wsize_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    rem_r     <= rem_nxt;
    s_r       <= s_nxt;
    old_r     <= old_nxt;
    rd_bin_r  <= rd_bin_nxt;
    out_sum_r <= out_sum_nxt;
    out_med_r <= out_med_nxt;
  end

  // Sample ring: read continuously at the current slot, written once per sample.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ptr_r] <= wmads_pkg::SAMPLE_W'(s_r);
    end
    ring_q <= ring_mem[ptr_r];
  end

  // Histogram: one read and one write port.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_q <= hist_mem[hist_ra];
  end

  assign scan_ctl.start = scan_start;
  assign scan_ctl.vld   = rd_vld_r;
  assign scan_ctl.last  = rd_last_r;

  wmads_scan #(
    .WINDOW_MAX   (WINDOW_MAX),
    .VALUE_LEVELS (VALUE_LEVELS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .bin     (rd_bin_r),
    .count   (hist_q),
    .k       (k_r),
    .rem     (rem_r),
    .done    (scan_done),
    .dev_sum (scan_sum),
    .median  (scan_med)
  );

  assign out_valid         = out_valid_r;
  assign out_deviation_sum = out_sum_r;
  assign out_window_median = out_med_r;

endmodule
